FILE: hw/rtl/smhs_pkg.sv
// Shared types, codes and constants of the spool motion heater supervisor.
package smhs_pkg;

	// Default width of the wrapping millisecond time base
	localparam int TIME_BITS_DEF = 32;

	// Field widths fixed by the register map and the event format
	localparam int NOW_W     = 32;
	localparam int COUNT_W   = 32;
	localparam int MODE_W    = 2;
	localparam int IDLE_W    = 10;
	localparam int GAP_W     = 16;
	localparam int PULSES_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Idle limit in ms: 1023 minutes * 60000 fits in 26 bits
	localparam int LIMIT_W = 26;

	localparam int unsigned MS_PER_MINUTE  = 60000;
	localparam int unsigned SAVE_PERIOD_MS = 600000;

	// Register reset values
	localparam logic [MODE_W-1:0]   MODE_RST         = 2'd0;
	localparam logic [IDLE_W-1:0]   IDLE_MINUTES_RST = 10'd30;
	localparam logic [GAP_W-1:0]    MIN_GAP_RST      = 16'd5;
	localparam logic [GAP_W-1:0]    MAX_GAP_RST      = 16'd500;
	localparam logic [PULSES_W-1:0] START_PULSES_RST = 8'd10;

	typedef enum logic [1:0] {
		OP_EDGE    = 2'd0,
		OP_POLL    = 2'd1,
		OP_RESTART = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF        = 2'd0,
		MODE_AUTO_START = 2'd1,
		MODE_AUTO_STOP  = 2'd2,
		MODE_BOTH       = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_IDLE_MINUTES = 3'd1,
		REG_MIN_GAP      = 3'd2,
		REG_MAX_GAP      = 3'd3,
		REG_START_PULSES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t                mode;
		logic [LIMIT_W-1:0]   idle_limit;
		logic [GAP_W-1:0]     min_gap;
		logic [GAP_W-1:0]     max_gap;
		logic [PULSES_W-1:0]  start_pulses;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic [NOW_W-1:0] now_ms;
		logic             heater_running;
		logic             lid_raised;
	} item_t;

	typedef struct packed {
		logic               start_heater;
		logic               stop_heater;
		logic               save_request;
		logic [COUNT_W-1:0] turn_pulses;
	} result_t;

endpackage

FILE: hw/rtl/smhs_evt_if.sv
// Event channel: valid/ready handshake carrying one timestamped event.
interface smhs_evt_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [smhs_pkg::NOW_W-1:0]    now_ms;
	logic                          heater_running;
	logic                          lid_raised;

	modport source (output valid, output op, output now_ms, output heater_running,
		output lid_raised, input ready);
	modport sink (input valid, input op, input now_ms, input heater_running,
		input lid_raised, output ready);
endinterface

FILE: hw/rtl/smhs_res_if.sv
// Result channel: valid/ready handshake carrying one supervisor result.
interface smhs_res_if;
	logic                          valid;
	logic                          ready;
	logic                          start_heater;
	logic                          stop_heater;
	logic                          save_request;
	logic [smhs_pkg::COUNT_W-1:0]  turn_pulses;

	modport source (output valid, output start_heater, output stop_heater,
		output save_request, output turn_pulses, input ready);
	modport sink (input valid, input start_heater, input stop_heater,
		input save_request, input turn_pulses, output ready);
endinterface

FILE: hw/rtl/smhs_core.sv
// Supervisor state and the single-pass event step that updates it.
module smhs_core #(
	parameter int TIME_BITS = smhs_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  smhs_pkg::item_t   item,
	input  smhs_pkg::cfg_t    cfg,
	input  logic              mode_wr,
	output smhs_pkg::result_t result
);

	localparam int CMP_W = (TIME_BITS > smhs_pkg::LIMIT_W) ? TIME_BITS : smhs_pkg::LIMIT_W;

	logic [smhs_pkg::COUNT_W-1:0]  pulse_total_q, pulse_total_n;
	logic [smhs_pkg::COUNT_W-1:0]  pulse_at_poll_q, pulse_at_poll_n;
	logic [TIME_BITS-1:0]          last_edge_q, last_edge_n;
	logic [smhs_pkg::PULSES_W-1:0] burst_q, burst_n;
	logic                          armed_q, armed_n;
	logic                          prev_heater_q, prev_heater_n;
	logic [TIME_BITS-1:0]          idle_since_q, idle_since_n;
	logic [TIME_BITS-1:0]          last_save_q, last_save_n;

	logic [TIME_BITS+smhs_pkg::NOW_W-1:0] now_wide;
	logic [TIME_BITS-1:0]          now_t;
	logic [TIME_BITS-1:0]          edge_d, idle_d, save_d;
	logic [smhs_pkg::PULSES_W-1:0] burst_inc;
	logic                          edge_ok, edge_close, poll_reset;
	logic                          start_en, stop_en;

	assign now_wide   = {{TIME_BITS{1'b0}}, item.now_ms};
	assign now_t      = now_wide[TIME_BITS-1:0];
	assign edge_d     = now_t - last_edge_q;
	assign idle_d     = now_t - idle_since_q;
	assign save_d     = now_t - last_save_q;
	assign burst_inc  = burst_q + 1'b1;
	assign edge_ok    = CMP_W'(edge_d) >= CMP_W'(cfg.min_gap);
	assign edge_close = CMP_W'(edge_d) <= CMP_W'(cfg.max_gap);
	assign poll_reset = (prev_heater_q != item.heater_running) || item.lid_raised;
	assign start_en   = (cfg.mode == smhs_pkg::MODE_AUTO_START)
		|| (cfg.mode == smhs_pkg::MODE_BOTH);
	assign stop_en    = (cfg.mode == smhs_pkg::MODE_AUTO_STOP)
		|| (cfg.mode == smhs_pkg::MODE_BOTH);

	always_comb begin
		pulse_total_n   = pulse_total_q;
		pulse_at_poll_n = pulse_at_poll_q;
		last_edge_n     = last_edge_q;
		burst_n         = burst_q;
		armed_n         = armed_q;
		prev_heater_n   = prev_heater_q;
		idle_since_n    = idle_since_q;
		last_save_n     = last_save_q;
		result          = '0;
		case (item.op)
			smhs_pkg::OP_EDGE: begin
				if (edge_ok) begin
					last_edge_n   = now_t;
					pulse_total_n = pulse_total_q + 1'b1;
					if (edge_close) begin
						if (burst_inc >= cfg.start_pulses) begin
							armed_n = 1'b1;
							burst_n = '0;
						end else begin
							burst_n = burst_inc;
						end
					end else begin
						burst_n = '0;
					end
				end
			end
			smhs_pkg::OP_POLL: begin
				if (poll_reset) begin
					burst_n = '0;
					armed_n = 1'b0;
				end
				prev_heater_n = item.heater_running;
				if (!item.heater_running) begin
					if (start_en) begin
						result.start_heater = armed_n && !item.lid_raised;
						idle_since_n        = now_t;
					end
				end else if (stop_en) begin
					if (pulse_total_q == pulse_at_poll_q) begin
						result.stop_heater = CMP_W'(cfg.idle_limit) <= CMP_W'(idle_d);
					end else begin
						idle_since_n = now_t;
					end
				end
				pulse_at_poll_n = pulse_total_q;
				if (CMP_W'(save_d) > CMP_W'(smhs_pkg::SAVE_PERIOD_MS)) begin
					result.save_request = 1'b1;
					last_save_n         = now_t;
				end
			end
			smhs_pkg::OP_RESTART: begin
				idle_since_n = now_t;
			end
			smhs_pkg::OP_CLEAR: begin
				pulse_total_n = '0;
			end
			default: begin
				pulse_total_n = pulse_total_q;
			end
		endcase
		result.turn_pulses = pulse_total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_total_q   <= '0;
			pulse_at_poll_q <= '0;
			last_edge_q     <= '0;
			burst_q         <= '0;
			armed_q         <= 1'b0;
			prev_heater_q   <= 1'b0;
			idle_since_q    <= '0;
			last_save_q     <= '0;
		end else if (mode_wr) begin
			burst_q <= '0;
			armed_q <= 1'b0;
		end else if (fire) begin
			pulse_total_q   <= pulse_total_n;
			pulse_at_poll_q <= pulse_at_poll_n;
			last_edge_q     <= last_edge_n;
			burst_q         <= burst_n;
			armed_q         <= armed_n;
			prev_heater_q   <= prev_heater_n;
			idle_since_q    <= idle_since_n;
			last_save_q     <= last_save_n;
		end
	end

endmodule

FILE: hw/rtl/spool_motion_heater_supervisor.sv
// Spool motion heater supervisor: top level with handshake, registers and checks.
// An accepted event is registered in the input stage, then its result in res_q.
// Throughput: one event per cycle unless the result channel stalls; each state update
// is a single pass of compares and adds, so events may follow back to back.
// Reset: arst_n clears all supervisor state and loads register defaults
// (mode 0, 30 idle minutes, 5 ms min gap, 500 ms max gap, 10 start pulses).
module spool_motion_heater_supervisor #(
	parameter int TIME_BITS = smhs_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	smhs_evt_if.sink                          evt,
	smhs_res_if.source                        res,
	input  logic                              cfg_wen,
	input  logic [smhs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [smhs_pkg::CFG_DAT_W-1:0]    cfg_data
);

	// Configuration registers; the idle limit is held already scaled to ms
	smhs_pkg::cfg_t              cfg_q;
	logic [smhs_pkg::LIMIT_W-1:0] idle_limit_wr;
	logic                        mode_wr;

	// Input stage and result register
	logic                        s1_valid_q;
	smhs_pkg::item_t             item_s1;
	logic                        res_valid_q;
	smhs_pkg::result_t           res_q;
	smhs_pkg::result_t           step_res;
	logic                        adv;

	// Scale minutes to ms at write time, keeping the multiply off the event path
	assign idle_limit_wr = smhs_pkg::LIMIT_W'(cfg_data[smhs_pkg::IDLE_W-1:0])
		* smhs_pkg::LIMIT_W'(smhs_pkg::MS_PER_MINUTE);
	assign mode_wr = cfg_wen && (cfg_idx == smhs_pkg::REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= smhs_pkg::mode_t'(smhs_pkg::MODE_RST);
			cfg_q.idle_limit   <= smhs_pkg::LIMIT_W'(smhs_pkg::IDLE_MINUTES_RST)
				* smhs_pkg::LIMIT_W'(smhs_pkg::MS_PER_MINUTE);
			cfg_q.min_gap      <= smhs_pkg::MIN_GAP_RST;
			cfg_q.max_gap      <= smhs_pkg::MAX_GAP_RST;
			cfg_q.start_pulses <= smhs_pkg::START_PULSES_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				smhs_pkg::REG_MODE:
					cfg_q.mode <= smhs_pkg::mode_t'(cfg_data[smhs_pkg::MODE_W-1:0]);
				smhs_pkg::REG_IDLE_MINUTES: cfg_q.idle_limit <= idle_limit_wr;
				smhs_pkg::REG_MIN_GAP:      cfg_q.min_gap    <= cfg_data[smhs_pkg::GAP_W-1:0];
				smhs_pkg::REG_MAX_GAP:      cfg_q.max_gap    <= cfg_data[smhs_pkg::GAP_W-1:0];
				smhs_pkg::REG_START_PULSES:
					cfg_q.start_pulses <= cfg_data[smhs_pkg::PULSES_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Advance the held event into the result register whenever that register is free
	// or its transaction completes this cycle; the input stage refills in the same cycle.
	assign adv       = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt.ready) begin
			s1_valid_q <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			item_s1.op             <= smhs_pkg::op_t'(evt.op);
			item_s1.now_ms         <= evt.now_ms;
			item_s1.heater_running <= evt.heater_running;
			item_s1.lid_raised     <= evt.lid_raised;
		end
	end

	// State update happens as the event leaves the input stage
	smhs_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.item    (item_s1),
		.cfg     (cfg_q),
		.mode_wr (mode_wr),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.start_heater = res_q.start_heater;
	assign res.stop_heater  = res_q.stop_heater;
	assign res.save_request = res_q.save_request;
	assign res.turn_pulses  = res_q.turn_pulses;

	// Commands only ever come from a poll
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.op != smhs_pkg::OP_POLL) |=>
		!res.start_heater && !res.stop_heater && !res.save_request)
		else $error("command raised by a non-poll transaction");

	// Start and stop depend on opposite heater states
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.start_heater && res.stop_heater))
		else $error("start and stop commanded together");

	// Input is held off only while both stages are full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> s1_valid_q && res_valid_q && !res.ready)
		else $error("event channel stalled without back-pressure");

	// A clear leaves the count at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.op == smhs_pkg::OP_CLEAR) |=> res.turn_pulses == '0)
		else $error("turn count not cleared");

endmodule

FILE: test/tb_spool_motion_heater_supervisor.sv
// Self-checking testbench for the spool motion heater supervisor, event and result channels.
`timescale 1ns / 100ps

module tb_spool_motion_heater_supervisor;
	import smhs_pkg::*;

	// Run shape
	localparam int unsigned LIMIT_CYCLES     = 400000;
	localparam int unsigned IDLE_PCT         = 26;
	localparam int unsigned HOLD_CYCLES      = 300;
	localparam int unsigned SETTLE_CYCLES    = 6;
	localparam int unsigned TAIL_CYCLES      = 20;
	localparam int unsigned ITEMS_PER_PHASE  = 169;
	localparam int unsigned RANDOM_PHASES    = 8;
	localparam int unsigned MAX_REPORTS      = 10;
	localparam int unsigned PRESSURE_PHASE   = 4;
	localparam int unsigned STEADY_PHASE     = 6;

	// Register indexes past the end of the map: writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_START_PULSES + 1);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = {CFG_IDX_W{1'b1}};

	// One queued event, with a hand-written expectation where the row carries one
	typedef struct {
		item_t   ev;
		bit      typed;
		result_t want;
	} queued_event_t;

	// One row of the directed table: either a register write or an event
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
		item_t                ev;
		bit                   typed;
		result_t              want;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DAT_W-1:0] cfg_data;

	smhs_evt_if evt ();
	smhs_res_if res ();

	spool_motion_heater_supervisor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.res      (res),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Stimulus waiting to be offered, and the results owed by the block
	queued_event_t event_queue[$];
	result_t       due_results[$];
	directed_row_t directed[$];

	// Handshake bookkeeping shared between the edge processes
	bit evt_taken;
	bit steady;
	bit hold_go;
	bit sink_hold;

	// Statistics
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned queued_items;
	int unsigned settings_used;
	int unsigned starts_seen;
	int unsigned stops_seen;
	int unsigned saves_seen;

	// Predictor copy of the registers
	mode_t                p_mode;
	logic [IDLE_W-1:0]    p_idle_min;
	logic [GAP_W-1:0]     p_min_gap;
	logic [GAP_W-1:0]     p_max_gap;
	logic [PULSES_W-1:0]  p_start_pulses;

	// Predictor copy of the supervisor state
	logic [COUNT_W-1:0]   p_pulse_total;
	logic [COUNT_W-1:0]   p_total_at_poll;
	logic [NOW_W-1:0]     p_last_edge;
	logic [PULSES_W-1:0]  p_burst;
	logic                 p_armed;
	logic                 p_prev_heater;
	logic [NOW_W-1:0]     p_idle_since;
	logic [NOW_W-1:0]     p_last_save;

	// Stimulus timeline and the heater state the generator pretends to see
	logic [NOW_W-1:0]     t_ms;
	logic                 heater_state;

	// ------------------------------------------------------------------
	// Clock: 2 ns period
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	task automatic reset_predictor();
		p_mode          = mode_t'(MODE_RST);
		p_idle_min      = IDLE_MINUTES_RST;
		p_min_gap       = MIN_GAP_RST;
		p_max_gap       = MAX_GAP_RST;
		p_start_pulses  = START_PULSES_RST;
		p_pulse_total   = '0;
		p_total_at_poll = '0;
		p_last_edge     = '0;
		p_burst         = '0;
		p_armed         = 1'b0;
		p_prev_heater   = 1'b0;
		p_idle_since    = '0;
		p_last_save     = '0;
	endtask

	// Advance the predicted state by one event and return the result it owes
	function automatic result_t supervise_event(item_t ev);
		result_t           r;
		logic [NOW_W-1:0]  gap;
		logic [NOW_W-1:0]  idle_ms;
		logic [NOW_W-1:0]  since_save;
		int unsigned       limit_ms;
		r = '0;
		case (ev.op)
		OP_EDGE: begin
			gap = ev.now_ms - p_last_edge;
			// Debounce first: an edge closer than min_gap leaves everything alone
			if (gap >= p_min_gap) begin
				p_last_edge   = ev.now_ms;
				p_pulse_total = p_pulse_total + 1'b1;
				if (gap <= p_max_gap) begin
					p_burst = p_burst + 1'b1;
					if (p_burst >= p_start_pulses) begin
						p_armed = 1'b1;
						p_burst = '0;
					end
				end else begin
					p_burst = '0;
				end
			end
		end
		OP_POLL: begin
			// Idle time is measured against the value held before this poll
			idle_ms = ev.now_ms - p_idle_since;
			if (p_prev_heater != ev.heater_running || ev.lid_raised) begin
				p_burst = '0;
				p_armed = 1'b0;
			end
			p_prev_heater = ev.heater_running;
			if (!ev.heater_running) begin
				if (p_mode == MODE_AUTO_START || p_mode == MODE_BOTH) begin
					r.start_heater = p_armed && !ev.lid_raised;
					p_idle_since   = ev.now_ms;
				end
			end else if (p_mode == MODE_AUTO_STOP || p_mode == MODE_BOTH) begin
				if (p_pulse_total == p_total_at_poll) begin
					limit_ms      = p_idle_min * MS_PER_MINUTE;
					r.stop_heater = (limit_ms <= idle_ms);
				end else begin
					p_idle_since = ev.now_ms;
				end
			end
			p_total_at_poll = p_pulse_total;
			since_save = ev.now_ms - p_last_save;
			if (since_save > SAVE_PERIOD_MS) begin
				r.save_request = 1'b1;
				p_last_save    = ev.now_ms;
			end
		end
		OP_RESTART: p_idle_since = ev.now_ms;
		default:    p_pulse_total = '0;
		endcase
		r.turn_pulses = p_pulse_total;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Register port: one write per call, mirrored into the predictor.
	// Call only at a falling edge with the block idle.
	// ------------------------------------------------------------------
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
		REG_MODE: begin
			// A mode write also drops any burst in progress and the armed start
			p_mode  = mode_t'(data[MODE_W-1:0]);
			p_burst = '0;
			p_armed = 1'b0;
		end
		REG_IDLE_MINUTES: p_idle_min     = data[IDLE_W-1:0];
		REG_MIN_GAP:      p_min_gap      = data[GAP_W-1:0];
		REG_MAX_GAP:      p_max_gap      = data[GAP_W-1:0];
		REG_START_PULSES: p_start_pulses = data[PULSES_W-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every offered event is in and every owed result is out
	task automatic wait_quiet();
		while (event_queue.size() != 0 || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_event(op_t op, logic [NOW_W-1:0] now, logic heater, logic lid);
		queued_event_t q;
		q.ev.op             = op;
		q.ev.now_ms         = now;
		q.ev.heater_running = heater;
		q.ev.lid_raised     = lid;
		q.typed             = 1'b0;
		q.want              = '0;
		event_queue.push_back(q);
		queued_items++;
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	function automatic directed_row_t ev_row(op_t op, logic [NOW_W-1:0] now, logic heater,
			logic lid);
		directed_row_t r;
		r.is_cfg            = 1'b0;
		r.idx               = '0;
		r.data              = '0;
		r.ev.op             = op;
		r.ev.now_ms         = now;
		r.ev.heater_running = heater;
		r.ev.lid_raised     = lid;
		r.typed             = 1'b0;
		r.want              = '0;
		return r;
	endfunction

	// Event row whose result can be written down directly
	function automatic directed_row_t typed_row(op_t op, logic [NOW_W-1:0] now, logic heater,
			logic lid, logic save, logic [COUNT_W-1:0] turns);
		directed_row_t r;
		r = ev_row(op, now, heater, lid);
		r.typed              = 1'b1;
		r.want.save_request  = save;
		r.want.turn_pulses   = turns;
		return r;
	endfunction

	function automatic directed_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DAT_W-1:0] data);
		directed_row_t r;
		r = ev_row(OP_EDGE, '0, 1'b0, 1'b0);
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	task automatic load_directed();
		// Reset defaults: mode off, min gap 5, max gap 500
		directed.push_back(typed_row(OP_CLEAR,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
		// Too close to the reset edge time: ignored
		directed.push_back(typed_row(OP_EDGE,    32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
		// Exactly min gap, heater and lid set but ignored by an edge
		directed.push_back(typed_row(OP_EDGE,    32'h0000_0005, 1'b1, 1'b1, 1'b0, 32'd1));
		// Top of the time range: long gap, accepted, breaks the burst
		directed.push_back(typed_row(OP_EDGE,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd2));
		// Poll far past the save period with mode off
		directed.push_back(typed_row(OP_POLL,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd2));
		// Restart ignores heater and lid
		directed.push_back(typed_row(OP_RESTART, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'd2));
		// Mode with the upper data bits set, and start pulses zero
		directed.push_back(cfg_row(REG_MODE, {CFG_DAT_W{1'b1}}));
		directed.push_back(cfg_row(REG_START_PULSES, '0));
		// Heater change clears, then a close edge across the wrap arms the start
		directed.push_back(ev_row(OP_POLL, 32'h0000_0020, 1'b0, 1'b0));
		directed.push_back(ev_row(OP_EDGE, 32'h0000_0040, 1'b0, 1'b0));
		// The start stays armed across polls until the lid opens
		directed.push_back(ev_row(OP_POLL, 32'h0000_0050, 1'b0, 1'b0));
		directed.push_back(ev_row(OP_POLL, 32'h0000_0060, 1'b0, 1'b0));
		directed.push_back(ev_row(OP_POLL, 32'h0000_0070, 1'b0, 1'b1));
		// Zero idle minutes: the first quiet poll with heater on stops it
		directed.push_back(cfg_row(REG_IDLE_MINUTES, '0));
		directed.push_back(ev_row(OP_POLL, 32'h0000_0080, 1'b1, 1'b0));
		directed.push_back(typed_row(OP_CLEAR, 32'h0000_0090, 1'b1, 1'b1, 1'b0, 32'd0));
		// Largest settings
		directed.push_back(cfg_row(REG_IDLE_MINUTES, {CFG_DAT_W{1'b1}}));
		directed.push_back(cfg_row(REG_MIN_GAP, {CFG_DAT_W{1'b1}}));
		directed.push_back(cfg_row(REG_MAX_GAP, {CFG_DAT_W{1'b1}}));
		directed.push_back(ev_row(OP_EDGE, 32'h0000_0100, 1'b0, 1'b0));
		directed.push_back(ev_row(OP_EDGE, 32'h0001_0040, 1'b0, 1'b0));
		// Index past the end of the map must change nothing
		directed.push_back(cfg_row(REG_LAST_CODE, {CFG_DAT_W{1'b1}}));
		directed.push_back(ev_row(OP_POLL, 32'h8000_0000, 1'b1, 1'b0));
		directed.push_back(ev_row(OP_POLL, 32'h8000_0001, 1'b1, 1'b0));
	endtask

	// ------------------------------------------------------------------
	// Random phases
	// ------------------------------------------------------------------
	task automatic apply_phase(int unsigned ph);
		logic [MODE_W-1:0]   mode;
		logic [IDLE_W-1:0]   idle;
		logic [GAP_W-1:0]    min_gap;
		logic [GAP_W-1:0]    max_gap;
		logic [PULSES_W-1:0] pulses;
		logic [CFG_DAT_W-1:0] mode_word;
		case (ph)
		0: begin mode = MODE_BOTH;       idle = 30;   min_gap = 5;     max_gap = 500;   pulses = 10;  end
		1: begin mode = MODE_AUTO_START; idle = 0;    min_gap = 0;     max_gap = 0;     pulses = 1;   end
		2: begin mode = MODE_AUTO_STOP;  idle = 1023; min_gap = 65535; max_gap = 65535; pulses = 255; end
		3: begin mode = MODE_BOTH;       idle = 1;    min_gap = 0;     max_gap = 65535; pulses = 0;   end
		default: begin
			mode    = MODE_W'($urandom_range(0, 3));
			idle    = IDLE_W'($urandom_range(0, 3));
			min_gap = GAP_W'($urandom_range(0, 20));
			max_gap = GAP_W'($urandom_range(20, 600));
			pulses  = PULSES_W'($urandom_range(0, 12));
		end
		endcase
		write_register(REG_IDLE_MINUTES, CFG_DAT_W'(idle));
		write_register(REG_MIN_GAP, min_gap);
		write_register(REG_MAX_GAP, max_gap);
		write_register(REG_START_PULSES, CFG_DAT_W'(pulses));
		// Junk in the upper bits of the mode word must be dropped
		mode_word = CFG_DAT_W'($urandom);
		mode_word[MODE_W-1:0] = mode;
		write_register(REG_MODE, mode_word);
		if (ph % 2 == 1)
			write_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_CODE)),
				CFG_DAT_W'($urandom));
		settings_used++;
	endtask

	// Queue one short sequence; most are the sequences a real spool produces
	task automatic queue_scenario();
		int unsigned kind;
		int unsigned n;
		int unsigned cap;
		int unsigned hi;
		int unsigned step;
		int unsigned limit_ms;
		logic [NOW_W-1:0] base;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			// Burst of encoder edges, with bounces and slow edges mixed in, then a poll
			cap = (p_start_pulses > 24) ? 24 : p_start_pulses;
			n = $urandom_range(1, cap + 2);
			if (p_start_pulses > 24 && $urandom_range(0, 31) == 0)
				n = p_start_pulses + 2;
			hi = (p_max_gap > p_min_gap) ? p_max_gap : p_min_gap;
			repeat (n) begin
				case ($urandom_range(0, 9))
				0:       step = (p_min_gap != 0) ? $urandom_range(0, p_min_gap - 1) : 0;
				1:       step = p_max_gap + $urandom_range(1, 1000);
				default: step = $urandom_range(p_min_gap, hi);
				endcase
				t_ms = t_ms + step;
				queue_event(OP_EDGE, t_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			t_ms = t_ms + $urandom_range(0, 50);
			queue_event(OP_POLL, t_ms, heater_state, $urandom_range(0, 15) == 0);
		end else if (kind < 65) begin
			// Idle wait: restart the timer, then poll around the timeout
			limit_ms = p_idle_min * MS_PER_MINUTE;
			t_ms = t_ms + $urandom_range(0, 100);
			base = t_ms;
			queue_event(OP_RESTART, base, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			queue_event(OP_POLL, base, heater_state, 1'b0);
			case ($urandom_range(0, 2))
			0:       t_ms = base + limit_ms - 1;
			1:       t_ms = base + limit_ms;
			default: t_ms = base + $urandom_range(0, limit_ms + limit_ms / 2 + 2000);
			endcase
			queue_event(OP_POLL, t_ms, heater_state, $urandom_range(0, 15) == 0);
		end else if (kind < 75) begin
			// Two polls either side of the save period
			queue_event(OP_POLL, t_ms, heater_state, 1'b0);
			t_ms = t_ms + SAVE_PERIOD_MS + $urandom_range(0, 1);
			queue_event(OP_POLL, t_ms, heater_state, 1'b0);
		end else if (kind < 82) begin
			t_ms = t_ms + $urandom_range(0, 1000);
			queue_event(OP_RESTART, t_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else if (kind < 87) begin
			queue_event(OP_CLEAR, t_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			// Noise: any op, any timestamp; sometimes move the timeline there too
			queue_event(op_t'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				t_ms = $urandom;
		end
		// The heater changes state now and then, as the controller would
		if ($urandom_range(0, 5) == 0)
			heater_state = ~heater_state;
	endtask

	// ------------------------------------------------------------------
	// Event source: drive at the falling edge, keep valid up until taken
	// ------------------------------------------------------------------
	initial begin
		evt.valid          = 1'b0;
		evt.op             = OP_EDGE;
		evt.now_ms         = '0;
		evt.heater_running = 1'b0;
		evt.lid_raised     = 1'b0;
		forever begin
			@(negedge clk);
			if (evt.valid && !evt_taken) begin
				// Hold the offered transaction until it is taken
			end else if (arst_n && event_queue.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				evt.valid          <= 1'b1;
				evt.op             <= event_queue[0].ev.op;
				evt.now_ms         <= event_queue[0].ev.now_ms;
				evt.heater_running <= event_queue[0].ev.heater_running;
				evt.lid_raised     <= event_queue[0].ev.lid_raised;
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result sink: random stalls, plus one long hold-off to fill the block
	// ------------------------------------------------------------------
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= !sink_hold && (steady || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		int unsigned held;
		sink_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		sink_hold = 1'b1;
		for (held = 0; held < HOLD_CYCLES; held++)
			@(posedge clk);
		sink_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted event, check each accepted result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		evt_taken = 1'b0;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.start_heater = res.start_heater;
				got.stop_heater  = res.stop_heater;
				got.save_request = res.save_request;
				got.turn_pulses  = res.turn_pulses;
				results_seen++;
				starts_seen += got.start_heater;
				stops_seen  += got.stop_heater;
				saves_seen  += got.save_request;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result with none owed: start=%b stop=%b save=%b turns=%0d",
							$realtime, got.start_heater, got.stop_heater, got.save_request,
							got.turn_pulses);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: result %0d: want start=%b stop=%b save=%b turns=%0d, got start=%b stop=%b save=%b turns=%0d",
								$realtime, results_seen, want.start_heater, want.stop_heater,
								want.save_request, want.turn_pulses, got.start_heater,
								got.stop_heater, got.save_request, got.turn_pulses);
					end
				end
			end
			if (evt.valid && evt.ready) begin
				// Always step the predictor; a typed row then replaces the whole expected result
				want = supervise_event(event_queue[0].ev);
				if (event_queue[0].typed)
					want = event_queue[0].want;
				due_results.push_back(want);
				void'(event_queue.pop_front());
				evt_taken = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d events and %0d results outstanding",
			cycles, event_queue.size(), due_results.size());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned ph;
		int unsigned phase_start;
		arst_n   = 1'b0;
		cfg_wen  = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		steady   = 1'b0;
		hold_go  = 1'b0;
		heater_state = 1'b0;
		reset_predictor();
		load_directed();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part: register rows wait for the block to drain first
		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				wait_quiet();
				write_register(directed[i].idx, directed[i].data);
			end else begin
				event_queue.push_back('{ev: directed[i].ev, typed: directed[i].typed,
					want: directed[i].want});
				queued_items++;
			end
		end
		wait_quiet();
		t_ms = 32'h8000_0001;

		// Random part, one register setting per phase
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == STEADY_PHASE)
				steady <= 1'b1;
			else
				steady <= 1'b0;
			apply_phase(ph);
			phase_start = queued_items;
			while (queued_items - phase_start < ITEMS_PER_PHASE)
				queue_scenario();
			// Stall the sink while a full phase of events waits at the input
			if (ph == PRESSURE_PHASE)
				hold_go <= 1'b1;
			wait_quiet();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Checked %0d results from %0d events over %0d register settings",
			results_seen, queued_items, settings_used);
		$display("Commands seen: %0d starts, %0d stops, %0d saves; %0d mismatches",
			starts_seen, stops_seen, saves_seen, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/smhs_pkg.sv
hw/rtl/smhs_evt_if.sv
hw/rtl/smhs_res_if.sv
hw/rtl/smhs_core.sv
hw/rtl/spool_motion_heater_supervisor.sv
test/tb_spool_motion_heater_supervisor.sv
